/* hw/rtl/nv4_pkg.sv */
// Shared types, constants and schedule figures for the 4-D value noise block.
package nv4_pkg;

  // Default parameter values
  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int VALUE_BITS_DEF = 16;

  // Fixed field widths of the stream items
  localparam int OP_BITS      = 2;
  localparam int COORD_BITS   = 24;
  localparam int ENTRY_BITS   = 8;
  localparam int LATTICE_BITS = 16;
  localparam int PERM_BITS    = 8;
  localparam int OUT_BITS     = 16;
  localparam int S_DATA_BITS  = 4 * COORD_BITS + ENTRY_BITS + LATTICE_BITS + PERM_BITS;
  localparam int M_DATA_BITS  = OUT_BITS;

  // Hash schedule: 2 time reads, 4 z reads, 8 y reads, 16 x reads, then 16 value reads
  localparam int STEP_BITS    = 6;
  localparam int HASH_Z_FIRST = 2;
  localparam int HASH_Y_FIRST = 6;
  localparam int HASH_X_FIRST = 14;
  localparam int HASH_STEPS   = 30;
  localparam int FETCH_LAST   = 45;

  // Blend schedule: 8 lerps along x, 4 along y, 2 along z, 1 along t
  localparam int LERP_BITS    = 4;
  localparam int LERP_Y_FIRST = 8;
  localparam int LERP_Z_FIRST = 12;
  localparam int LERP_T_FIRST = 14;
  localparam int LERP_COUNT   = 15;

  // Queue depth for hash results and lattice values
  localparam int QUEUE_DEPTH = 16;

  typedef enum logic [OP_BITS-1:0] {
    OP_EVAL       = 2'd0,
    OP_LOAD_VALUE = 2'd1,
    OP_LOAD_PERM  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_T = 2'd3
  } axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_FETCH,
    ST_BLEND,
    ST_WAIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  start;
    logic  wr_value;
    logic  wr_perm;
    logic  perm_rd;
    axis_t hash_axis;
    logic  step_odd;
    logic  use_head;
    logic  pop_hash;
    logic  val_rd;
    logic  lerp_a;
    axis_t lerp_axis;
    logic  lerp_b;
    logic  out_load;
  } cmd_t;

endpackage

/* hw/rtl/nv4_ram.sv */
// Generic single-port RAM with registered read data.
module nv4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access a cycle: write, or read into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* hw/rtl/nv4_queue.sv */
// Shift queue: head read at fixed places, push at the tail, pop of up to two entries a cycle.
module nv4_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic [1:0]       pop_cnt,
  output logic [WIDTH-1:0] head0,
  output logic [WIDTH-1:0] head1
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entry      [DEPTH];
  logic [WIDTH-1:0]    entry_next [DEPTH];
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  logic [CNT_BITS-1:0] wr_pos;

  assign head0 = entry[0];
  assign head1 = entry[1];

  // Shift towards the head by the pop count, then write the pushed item at the new tail.
  always_comb begin
    wr_pos = count - CNT_BITS'(pop_cnt);
    for (int i = 0; i < DEPTH; i++) begin
      entry_next[i] = entry[i];
      if (pop_cnt == 2'd1 && i + 1 < DEPTH) begin
        entry_next[i] = entry[i + 1];
      end
      if (pop_cnt == 2'd2 && i + 2 < DEPTH) begin
        entry_next[i] = entry[i + 2];
      end
      if (push && wr_pos == CNT_BITS'(i)) begin
        entry_next[i] = push_data;
      end
    end
    if (clear) begin
      count_next = '0;
    end else begin
      count_next = wr_pos + CNT_BITS'(push);
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Entries
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      entry[i] <= entry_next[i];
    end
  end

endmodule

/* hw/rtl/nv4_ctrl.sv */
// Controller: item decode, hash and fetch step counter, blend sequencing and result handshake.
module nv4_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [nv4_pkg::OP_BITS-1:0]   operation,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nv4_pkg::cmd_t                 cmd
);

  nv4_pkg::state_t                   state;
  nv4_pkg::state_t                   state_next;
  logic [nv4_pkg::STEP_BITS-1:0]     step;
  logic [nv4_pkg::STEP_BITS-1:0]     step_next;
  logic [nv4_pkg::LERP_BITS-1:0]     lerp_n;
  logic [nv4_pkg::LERP_BITS-1:0]     lerp_n_next;
  logic                              phase;
  logic                              phase_next;
  logic                              accept;

  assign in_ready = (state == nv4_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  // State, counters and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nv4_pkg::ST_IDLE;
      step      <= '0;
      lerp_n    <= '0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      step   <= step_next;
      lerp_n <= lerp_n_next;
      phase  <= phase_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    step_next   = step;
    lerp_n_next = lerp_n;
    phase_next  = phase;
    cmd         = '0;
    case (state)
      nv4_pkg::ST_IDLE: begin
        if (accept) begin
          case (nv4_pkg::op_t'(operation))
            nv4_pkg::OP_EVAL: begin
              cmd.start  = 1'b1;
              step_next  = '0;
              state_next = nv4_pkg::ST_HASH;
            end
            nv4_pkg::OP_LOAD_VALUE: begin
              cmd.wr_value = 1'b1;
            end
            nv4_pkg::OP_LOAD_PERM: begin
              cmd.wr_perm = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      nv4_pkg::ST_HASH: begin
        // Breadth-first walk of the hash tree; each parent serves two children.
        cmd.perm_rd  = 1'b1;
        cmd.step_odd = step[0];
        cmd.use_head = (step >= nv4_pkg::STEP_BITS'(nv4_pkg::HASH_Z_FIRST));
        cmd.pop_hash = cmd.use_head && step[0];
        if (step < nv4_pkg::STEP_BITS'(nv4_pkg::HASH_Z_FIRST)) begin
          cmd.hash_axis = nv4_pkg::AXIS_T;
        end else if (step < nv4_pkg::STEP_BITS'(nv4_pkg::HASH_Y_FIRST)) begin
          cmd.hash_axis = nv4_pkg::AXIS_Z;
        end else if (step < nv4_pkg::STEP_BITS'(nv4_pkg::HASH_X_FIRST)) begin
          cmd.hash_axis = nv4_pkg::AXIS_Y;
        end else begin
          cmd.hash_axis = nv4_pkg::AXIS_X;
        end
        step_next = step + 1'b1;
        if (step == nv4_pkg::STEP_BITS'(nv4_pkg::HASH_STEPS - 1)) begin
          state_next = nv4_pkg::ST_FETCH;
        end
      end
      nv4_pkg::ST_FETCH: begin
        cmd.val_rd = 1'b1;
        step_next  = step + 1'b1;
        if (step == nv4_pkg::STEP_BITS'(nv4_pkg::FETCH_LAST)) begin
          lerp_n_next = '0;
          phase_next  = 1'b0;
          state_next  = nv4_pkg::ST_BLEND;
        end
      end
      nv4_pkg::ST_BLEND: begin
        // Each lerp has a multiply step followed by an add step.
        if (!phase) begin
          cmd.lerp_a = 1'b1;
          phase_next = 1'b1;
        end else begin
          cmd.lerp_b  = 1'b1;
          phase_next  = 1'b0;
          lerp_n_next = lerp_n + 1'b1;
          if (lerp_n == nv4_pkg::LERP_BITS'(nv4_pkg::LERP_COUNT - 1)) begin
            state_next = nv4_pkg::ST_WAIT;
          end
        end
        if (lerp_n < nv4_pkg::LERP_BITS'(nv4_pkg::LERP_Y_FIRST)) begin
          cmd.lerp_axis = nv4_pkg::AXIS_X;
        end else if (lerp_n < nv4_pkg::LERP_BITS'(nv4_pkg::LERP_Z_FIRST)) begin
          cmd.lerp_axis = nv4_pkg::AXIS_Y;
        end else if (lerp_n < nv4_pkg::LERP_BITS'(nv4_pkg::LERP_T_FIRST)) begin
          cmd.lerp_axis = nv4_pkg::AXIS_Z;
        end else begin
          cmd.lerp_axis = nv4_pkg::AXIS_T;
        end
      end
      nv4_pkg::ST_WAIT: begin
        // Hand the result over once the output register is free.
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = nv4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nv4_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/nv4_dp.sv */
// Datapath: coordinate split, table RAMs, hash and value queues, lerp unit and output register.
module nv4_dp #(
  parameter int TABLE_SIZE = nv4_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = nv4_pkg::FRAC_BITS_DEF,
  parameter int VALUE_BITS = nv4_pkg::VALUE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  nv4_pkg::cmd_t                             cmd,
  input  logic signed [nv4_pkg::COORD_BITS-1:0]     coord_x,
  input  logic signed [nv4_pkg::COORD_BITS-1:0]     coord_y,
  input  logic signed [nv4_pkg::COORD_BITS-1:0]     coord_z,
  input  logic signed [nv4_pkg::COORD_BITS-1:0]     coord_t,
  input  logic [nv4_pkg::ENTRY_BITS-1:0]            entry_index,
  input  logic signed [nv4_pkg::LATTICE_BITS-1:0]   lattice_value,
  input  logic [nv4_pkg::PERM_BITS-1:0]             perm_value,
  output logic signed [nv4_pkg::OUT_BITS-1:0]       noise_value
);

  localparam int IDX_BITS  = $clog2(TABLE_SIZE);
  localparam int EXT_BITS  = nv4_pkg::COORD_BITS + FRAC_BITS + IDX_BITS;
  localparam int PROD_BITS = VALUE_BITS + FRAC_BITS + 2;

  logic [IDX_BITS-1:0]                   ip   [4];
  logic [FRAC_BITS-1:0]                  frac [4];
  logic signed [EXT_BITS-1:0]            ext_x, ext_y, ext_z, ext_t;
  logic [IDX_BITS+nv4_pkg::ENTRY_BITS-1:0] idx_wide;
  logic [IDX_BITS-1:0]                   entry_idx;
  logic [VALUE_BITS+nv4_pkg::LATTICE_BITS-1:0] lv_wide;
  logic [IDX_BITS+nv4_pkg::PERM_BITS-1:0] perm_wide;

  logic [IDX_BITS-1:0]                   hash_addr;
  logic [nv4_pkg::PERM_BITS-1:0]         perm_rdata;
  logic [VALUE_BITS-1:0]                 value_rdata;
  logic                                  perm_pend;
  logic                                  val_pend;
  logic [IDX_BITS-1:0]                   hq_head;
  logic [1:0]                            hq_pop;

  logic                                  vq_push;
  logic [VALUE_BITS-1:0]                 vq_push_data;
  logic [VALUE_BITS-1:0]                 vq_head0;
  logic [VALUE_BITS-1:0]                 vq_head1;

  logic signed [VALUE_BITS:0]            lerp_diff;
  logic signed [PROD_BITS-1:0]           lerp_prod;
  logic signed [PROD_BITS-1:0]           prod_reg;
  logic signed [VALUE_BITS-1:0]          a_reg;
  logic signed [PROD_BITS-1:0]           lerp_sum;
  logic [VALUE_BITS-1:0]                 lerp_res;
  logic signed [VALUE_BITS+nv4_pkg::OUT_BITS-1:0] out_wide;

  // Coordinate split: integer part taken from the sign-extended word, fraction from the low bits.
  assign ext_x = EXT_BITS'(coord_x);
  assign ext_y = EXT_BITS'(coord_y);
  assign ext_z = EXT_BITS'(coord_z);
  assign ext_t = EXT_BITS'(coord_t);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ip[nv4_pkg::AXIS_X]   <= ext_x[FRAC_BITS +: IDX_BITS];
      ip[nv4_pkg::AXIS_Y]   <= ext_y[FRAC_BITS +: IDX_BITS];
      ip[nv4_pkg::AXIS_Z]   <= ext_z[FRAC_BITS +: IDX_BITS];
      ip[nv4_pkg::AXIS_T]   <= ext_t[FRAC_BITS +: IDX_BITS];
      frac[nv4_pkg::AXIS_X] <= coord_x[FRAC_BITS-1:0];
      frac[nv4_pkg::AXIS_Y] <= coord_y[FRAC_BITS-1:0];
      frac[nv4_pkg::AXIS_Z] <= coord_z[FRAC_BITS-1:0];
      frac[nv4_pkg::AXIS_T] <= coord_t[FRAC_BITS-1:0];
    end
  end

  // Load data fitted to the table widths
  assign idx_wide  = (IDX_BITS + nv4_pkg::ENTRY_BITS)'(entry_index);
  assign entry_idx = idx_wide[IDX_BITS-1:0];
  assign lv_wide   = (VALUE_BITS + nv4_pkg::LATTICE_BITS)'($unsigned(lattice_value));

  // Hash step address: axis integer part, plus one for the odd child, plus the parent hash.
  assign hash_addr = ip[cmd.hash_axis] + IDX_BITS'(cmd.step_odd)
                   + (cmd.use_head ? hq_head : IDX_BITS'(0));

  nv4_ram #(
    .WIDTH (nv4_pkg::PERM_BITS),
    .DEPTH (TABLE_SIZE)
  ) u_perm_ram (
    .clk   (clk),
    .en    (cmd.perm_rd || cmd.wr_perm),
    .we    (cmd.wr_perm),
    .addr  (cmd.wr_perm ? entry_idx : hash_addr),
    .wdata (perm_value),
    .rdata (perm_rdata)
  );

  nv4_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TABLE_SIZE)
  ) u_value_ram (
    .clk   (clk),
    .en    (cmd.val_rd || cmd.wr_value),
    .we    (cmd.wr_value),
    .addr  (cmd.wr_value ? entry_idx : hq_head),
    .wdata (lv_wide[VALUE_BITS-1:0]),
    .rdata (value_rdata)
  );

  // Read data arrives in the cycle after the address; these flags mark it for the queues.
  always_ff @(posedge clk) begin
    if (rst) begin
      perm_pend <= 1'b0;
      val_pend  <= 1'b0;
    end else begin
      perm_pend <= cmd.perm_rd;
      val_pend  <= cmd.val_rd;
    end
  end

  // Hash results in tree order; a parent leaves after its second child, a leaf after its fetch.
  assign perm_wide = (IDX_BITS + nv4_pkg::PERM_BITS)'(perm_rdata);
  assign hq_pop    = (cmd.pop_hash || cmd.val_rd) ? 2'd1 : 2'd0;

  nv4_queue #(
    .WIDTH (IDX_BITS),
    .DEPTH (nv4_pkg::QUEUE_DEPTH)
  ) u_hash_q (
    .clk       (clk),
    .rst       (rst),
    .clear     (cmd.start),
    .push      (perm_pend),
    .push_data (perm_wide[IDX_BITS-1:0]),
    .pop_cnt   (hq_pop),
    .head0     (hq_head),
    .head1     ()
  );

  // Lattice values, then lerp results, in tree order; each lerp takes the two oldest.
  assign vq_push      = val_pend || cmd.lerp_b;
  assign vq_push_data = cmd.lerp_b ? lerp_res : value_rdata;

  nv4_queue #(
    .WIDTH (VALUE_BITS),
    .DEPTH (nv4_pkg::QUEUE_DEPTH)
  ) u_value_q (
    .clk       (clk),
    .rst       (rst),
    .clear     (cmd.start),
    .push      (vq_push),
    .push_data (vq_push_data),
    .pop_cnt   (cmd.lerp_a ? 2'd2 : 2'd0),
    .head0     (vq_head0),
    .head1     (vq_head1)
  );

  // Lerp, first cycle: difference times weight.
  assign lerp_diff = (VALUE_BITS + 1)'($signed(vq_head1)) - (VALUE_BITS + 1)'($signed(vq_head0));
  assign lerp_prod = PROD_BITS'(lerp_diff) * PROD_BITS'($signed({1'b0, frac[cmd.lerp_axis]}));

  always_ff @(posedge clk) begin
    if (cmd.lerp_a) begin
      prod_reg <= lerp_prod;
      a_reg    <= $signed(vq_head0);
    end
  end

  // Lerp, second cycle: floor shift and add; the result stays between its operands.
  assign lerp_sum = PROD_BITS'(a_reg) + (prod_reg >>> FRAC_BITS);
  assign lerp_res = lerp_sum[VALUE_BITS-1:0];

  // Output register
  assign out_wide = (VALUE_BITS + nv4_pkg::OUT_BITS)'($signed(vq_head0));

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      noise_value <= out_wide[nv4_pkg::OUT_BITS-1:0];
    end
  end

endmodule

/* hw/rtl/value_noise_4d.sv */
// Top level of the 4-D quadrilinear value noise block.
//
//   Channel  Direction  Handshake                     Payload
//   s_axis   in         s_axis_tvalid/s_axis_tready   tuser: operation; tdata: coords, loads
//   m_axis   out        m_axis_tvalid/m_axis_tready   tdata: noise_value
//
// A load item is written as it is accepted, and the input stays open. An evaluate item
// runs 30 chained reads of the single-port permutation RAM, 16 value RAM reads, and
// 15 lerps (a multiply step and an add step each) through one shared multiplier, then loads
// the output register. The input reopens with the result, so evaluate items never overlap.
// Reset (rst, synchronous) clears the controller and queue counts; the tables are not cleared.
// A stalled result holds in the output register; loads may still be accepted meanwhile, and
// a later evaluate waits in its last cycle until that register is free.
module value_noise_4d #(
  parameter int TABLE_SIZE = nv4_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = nv4_pkg::FRAC_BITS_DEF,
  parameter int VALUE_BITS = nv4_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // coord_x, coord_y, coord_z, coord_t, entry_index, lattice_value, perm_value (lowest first)
  input  logic [nv4_pkg::S_DATA_BITS-1:0]   s_axis_tdata,
  // operation
  input  logic [nv4_pkg::OP_BITS-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // noise_value
  output logic [nv4_pkg::M_DATA_BITS-1:0]   m_axis_tdata
);

  localparam int CB = nv4_pkg::COORD_BITS;

  nv4_pkg::cmd_t                         cmd;
  logic signed [nv4_pkg::OUT_BITS-1:0]   noise_value;

  nv4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .operation (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  nv4_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .coord_x       ($signed(s_axis_tdata[0*CB +: CB])),
    .coord_y       ($signed(s_axis_tdata[1*CB +: CB])),
    .coord_z       ($signed(s_axis_tdata[2*CB +: CB])),
    .coord_t       ($signed(s_axis_tdata[3*CB +: CB])),
    .entry_index   (s_axis_tdata[4*CB +: nv4_pkg::ENTRY_BITS]),
    .lattice_value ($signed(s_axis_tdata[4*CB + nv4_pkg::ENTRY_BITS +: nv4_pkg::LATTICE_BITS])),
    .perm_value    (s_axis_tdata[4*CB + nv4_pkg::ENTRY_BITS + nv4_pkg::LATTICE_BITS +:
                                 nv4_pkg::PERM_BITS]),
    .noise_value   (noise_value)
  );

  assign m_axis_tdata = noise_value;

endmodule

/* hw/rtl/nv4_checker.sv */
// Port-level checks of the value noise block, bound to its top level.
module nv4_port_checks (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [nv4_pkg::OP_BITS-1:0]      s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [nv4_pkg::M_DATA_BITS-1:0]  m_axis_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No result can appear in the cycle right after an item is taken.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared straight after an item was taken");

  // An evaluate item keeps the input closed while it is worked on.
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == nv4_pkg::OP_EVAL
      |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input reopened during an evaluate item");

endmodule

bind value_noise_4d nv4_port_checks u_nv4_port_checks (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* dv/nv4_checker.sv */
// Checker for the 4-D value noise block: tracks both tables, predicts and compares results.
`timescale 1ns / 100ps

module nv4_checker
  import nv4_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // coord_x, coord_y, coord_z, coord_t, entry_index, lattice_value, perm_value (lowest first)
  input  logic [S_DATA_BITS-1:0] s_axis_tdata,
  // operation
  input  logic [OP_BITS-1:0]     s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // noise_value
  input  logic [M_DATA_BITS-1:0] m_axis_tdata,
  output int                     pending_count,
  output int                     failures
);

  // Bit offsets of the load fields within the input data word
  localparam int ENTRY_LO   = 4 * COORD_BITS;
  localparam int LATTICE_LO = ENTRY_LO + ENTRY_BITS;
  localparam int PERM_LO    = LATTICE_LO + LATTICE_BITS;

  // Shadow copies of the two tables, as the loads have written them
  int                   lattice_mem [TABLE_SIZE_DEF];
  logic [PERM_BITS-1:0] perm_mem    [TABLE_SIZE_DEF];

  // Noise values still owed by the block, oldest first
  logic [OUT_BITS-1:0]  noise_due [$];
  int                   backlog    = 0;
  int                   fail_count = 0;

  assign pending_count = backlog;
  assign failures      = fail_count;

  initial begin
    for (int i = 0; i < TABLE_SIZE_DEF; i++) begin
      lattice_mem[i] = 0;
      perm_mem[i]    = '0;
    end
  end

  // Chained permutation hash of one lattice corner, then the value lookup.
  function automatic int corner_value(logic [7:0] xc, logic [7:0] yc, logic [7:0] zc,
                                      logic [7:0] tc);
    logic [7:0] h;
    logic [7:0] sum;
    h   = perm_mem[tc];
    sum = zc + h;
    h   = perm_mem[sum];
    sum = yc + h;
    h   = perm_mem[sum];
    sum = xc + h;
    h   = perm_mem[sum];
    return lattice_mem[h];
  endfunction

  // Fixed-point lerp; the arithmetic shift rounds towards minus infinity.
  function automatic int blend(int a, int b, logic [7:0] w);
    int p;
    p = (b - a) * int'(w);
    return a + (p >>> FRAC_BITS_DEF);
  endfunction

  // Expected noise for one evaluate item: x first, then y, z and finally t.
  function automatic logic [OUT_BITS-1:0] quadrilinear_noise(logic [S_DATA_BITS-1:0] d);
    logic [7:0] base [4];
    logic [7:0] frac [4];
    logic [7:0] xs, ys, zs, ts;
    int         c [8];
    int         half [2];
    int         fv, bv, mixed;
    for (int k = 0; k < 4; k++) begin
      frac[k] = d[k*COORD_BITS +: 8];
      base[k] = d[k*COORD_BITS + FRAC_BITS_DEF +: 8];
    end
    for (int i = 0; i < 2; i++) begin
      ts = base[3] + 8'(i);
      // Corner j: bit 0 steps x, bit 1 steps y, bit 2 steps z
      for (int j = 0; j < 8; j++) begin
        xs = base[0] + 8'(j & 1);
        ys = base[1] + 8'((j >> 1) & 1);
        zs = base[2] + 8'((j >> 2) & 1);
        c[j] = corner_value(xs, ys, zs, ts);
      end
      fv = blend(blend(c[0], c[1], frac[0]), blend(c[2], c[3], frac[0]), frac[1]);
      bv = blend(blend(c[4], c[5], frac[0]), blend(c[6], c[7], frac[0]), frac[1]);
      half[i] = blend(fv, bv, frac[2]);
    end
    mixed = blend(half[0], half[1], frac[3]);
    return OUT_BITS'(mixed);
  endfunction

  task automatic note_failure(input string what, input logic [OUT_BITS-1:0] expected,
                              input logic [OUT_BITS-1:0] actual);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%t: %s: expected %0d, got %0d", $realtime, what, $signed(expected),
               $signed(actual));
    end
  endtask

  // Both channels are sampled at the rising edge, in the same way as the block sees them.
  always @(posedge clk) begin
    logic [OUT_BITS-1:0] expected;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          OP_LOAD_VALUE: begin
            lattice_mem[s_axis_tdata[ENTRY_LO +: ENTRY_BITS]] =
              int'($signed(s_axis_tdata[LATTICE_LO +: LATTICE_BITS]));
          end
          OP_LOAD_PERM: begin
            perm_mem[s_axis_tdata[ENTRY_LO +: ENTRY_BITS]] = s_axis_tdata[PERM_LO +: PERM_BITS];
          end
          OP_EVAL: begin
            noise_due.push_back(quadrilinear_noise(s_axis_tdata));
          end
          default: begin
            // The unused operation code leaves everything unchanged.
          end
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (noise_due.size() == 0) begin
          note_failure("noise result with nothing outstanding", 'x, m_axis_tdata);
        end else begin
          expected = noise_due.pop_front();
          if (m_axis_tdata !== expected) begin
            note_failure("noise value mismatch", expected, m_axis_tdata);
          end
        end
      end
    end
    backlog <= noise_due.size();
  end

endmodule

/* dv/tb_top.sv */
// Top of the value noise testbench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 100ps

module tb_top;
  import nv4_pkg::*;

  // The operation code that the block must ignore
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 200;

  // Layout of the input data word; the last member sits in the lowest bits
  typedef struct packed {
    logic [PERM_BITS-1:0]    perm_value;
    logic [LATTICE_BITS-1:0] lattice_value;
    logic [ENTRY_BITS-1:0]   entry_index;
    logic [COORD_BITS-1:0]   coord_t;
    logic [COORD_BITS-1:0]   coord_z;
    logic [COORD_BITS-1:0]   coord_y;
    logic [COORD_BITS-1:0]   coord_x;
  } noise_item_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_DATA_BITS-1:0] s_axis_tdata  = '0;
  logic [OP_BITS-1:0]     s_axis_tuser  = OP_EVAL;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_DATA_BITS-1:0] m_axis_tdata;

  int   pending_count;
  int   failures;
  int   cycle_count = 0;
  int   ready_hold  = 0;
  logic calm        = 1'b0;

  always #10 clk = ~clk;

  value_noise_4d DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  nv4_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_count (pending_count),
    .failures      (failures)
  );

  // Result side: stretches of readiness broken by stalls of random length.
  always @(posedge clk) begin
    if (rst || calm) begin
      m_axis_tready <= 1'b1;
      ready_hold    <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b1;
      ready_hold    <= $urandom_range(0, 30);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[value_noise_4d] ERROR");
      $finish;
    end
  end

  function automatic noise_item_t scrambled_item();
    return noise_item_t'({$urandom, $urandom, $urandom, $urandom});
  endfunction

  // Coordinates near zero, on the wrap of the masked integer part, or anywhere.
  function automatic logic [COORD_BITS-1:0] shaped_coord();
    case ($urandom_range(0, 3))
      0: return COORD_BITS'($urandom_range(0, 4095)) - COORD_BITS'(2048);
      1: return {8'($urandom), ($urandom_range(0, 1) ? 8'hFF : 8'h00), 8'($urandom)};
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // Present one item and hold it until the block takes it; valid stays high afterwards.
  task automatic push_item(input logic [OP_BITS-1:0] op, input noise_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= it;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic load_entry(input logic [OP_BITS-1:0] op, input int index,
                            input logic [LATTICE_BITS-1:0] lattice,
                            input logic [PERM_BITS-1:0] perm);
    noise_item_t it;
    it               = scrambled_item();
    it.entry_index   = ENTRY_BITS'(index);
    it.lattice_value = lattice;
    it.perm_value    = perm;
    maybe_pause();
    push_item(op, it);
  endtask

  task automatic evaluate_at(input logic [COORD_BITS-1:0] xc, input logic [COORD_BITS-1:0] yc,
                             input logic [COORD_BITS-1:0] zc, input logic [COORD_BITS-1:0] tc);
    noise_item_t it;
    it         = scrambled_item();
    it.coord_x = xc;
    it.coord_y = yc;
    it.coord_z = zc;
    it.coord_t = tc;
    maybe_pause();
    push_item(OP_EVAL, it);
  endtask

  // Mostly evaluates, with table rewrites and the odd ignored code in between.
  task automatic random_items(input int count);
    noise_item_t it;
    int          done;
    int          pick;
    done = 0;
    while (done < count) begin
      maybe_pause();
      pick = $urandom_range(0, 99);
      it   = scrambled_item();
      if (pick < 4) begin
        push_item(OP_UNUSED, it);
      end else begin
        if (pick < 14) begin
          push_item(OP_LOAD_VALUE, it);
        end else if (pick < 24) begin
          push_item(OP_LOAD_PERM, it);
        end else begin
          it.coord_x = shaped_coord();
          it.coord_y = shaped_coord();
          it.coord_z = shaped_coord();
          it.coord_t = shaped_coord();
          push_item(OP_EVAL, it);
        end
        done++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every entry of both tables is written before the first evaluate reads any.
    for (int i = 0; i < TABLE_SIZE_DEF; i++) begin
      load_entry(OP_LOAD_VALUE, i, LATTICE_BITS'($urandom), '0);
      load_entry(OP_LOAD_PERM, i, '0, PERM_BITS'($urandom));
    end

    // Directed: extreme table contents and coordinates, and the ignored code.
    load_entry(OP_LOAD_VALUE, 0, 16'h8000, '0);
    load_entry(OP_LOAD_VALUE, 255, 16'h7FFF, '0);
    load_entry(OP_LOAD_PERM, 0, '0, 8'hFF);
    load_entry(OP_LOAD_PERM, 255, '0, 8'h00);
    evaluate_at(24'h000000, 24'h000000, 24'h000000, 24'h000000);
    evaluate_at(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    evaluate_at(24'h800000, 24'h800000, 24'h800000, 24'h800000);
    evaluate_at(24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF);
    evaluate_at(24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 24'hFFFF00);
    evaluate_at(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    evaluate_at(24'h7FFFFF, 24'h800000, 24'h000080, 24'hFFFF01);
    maybe_pause();
    push_item(OP_UNUSED, scrambled_item());
    evaluate_at(24'h000180, 24'hFFFE7F, 24'h0000FF, 24'h000001);

    random_items(650);

    // Hold back until the block has answered everything outstanding.
    drain();

    // Value table with only the two extremes, so the lerps see the widest spans.
    for (int i = 0; i < TABLE_SIZE_DEF; i++) begin
      load_entry(OP_LOAD_VALUE, i, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000, '0);
    end
    random_items(300);

    // Last stretch runs without idling on either side.
    calm <= 1'b1;
    random_items(150);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[value_noise_4d] OK");
    end else begin
      $display("[value_noise_4d] ERROR");
    end
    $finish;
  end

endmodule
